// ----- rtl/rmts_pkg.sv -----
// Shared types and constants of the rate monotonic tick scheduler.
package rmts_pkg;

  localparam int SLOT_W     = 16;
  localparam int TASK_W     = 2;
  localparam int FILL_W     = 2;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WCET_A      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HYPERPERIOD = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REL,
    ST_BUB,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic clear;
    logic div_step;
    logic div_first;
    logic div_last;
    logic div_bit;
    logic job_start;
    logic dec;
    logic advance;
    logic wrap;
  } task_ctl_t;

  typedef struct packed {
    logic due;
    logic busy;
    logic dirty;
  } task_sts_t;

  typedef struct packed {
    logic              load;
    logic [TASK_W-1:0] idx;
    logic              take_dn;
    logic              take_up;
  } stk_ctl_t;

endpackage

// ----- rtl/rmts_task_cell.sv -----
// Per-task cell: period, WCET, remaining work and slot phase with a serial remainder step.
module rmts_task_cell import rmts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  period_we,
  input  logic                  wcet_we,
  input  logic [CFG_DATA_W-1:0] wdata,
  input  task_ctl_t             ctl,
  output logic [SLOT_W-1:0]     eff_period,
  output logic [SLOT_W-1:0]     work,
  output task_sts_t             sts
);

  logic [SLOT_W-1:0] period_r, wcet_r, work_r, mod_r;
  logic              dirty_r;
  logic [SLOT_W-1:0] eff_wcet, div_base, div_nxt, adv_nxt;
  logic [SLOT_W:0]   trial, inc;

  assign eff_period = (period_r == '0) ? SLOT_W'(1) : period_r;
  assign eff_wcet   = (wcet_r == '0) ? SLOT_W'(1) : wcet_r;

  // one restoring remainder step: slot bits enter msb first
  assign div_base = ctl.div_first ? '0 : mod_r;
  assign trial    = {div_base, ctl.div_bit};
  assign div_nxt  = (trial >= {1'b0, eff_period}) ? SLOT_W'(trial - {1'b0, eff_period})
                                                  : trial[SLOT_W-1:0];

  assign inc     = {1'b0, mod_r} + (SLOT_W+1)'(1);
  assign adv_nxt = (ctl.wrap || inc == {1'b0, eff_period}) ? '0 : inc[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= SLOT_W'(1);
      wcet_r   <= SLOT_W'(1);
      work_r   <= '0;
      mod_r    <= '0;
      dirty_r  <= 1'b0;
    end else begin
      if (period_we) begin
        period_r <= wdata;
      end
      if (wcet_we) begin
        wcet_r <= wdata;
      end
      priority if (period_we) begin
        dirty_r <= 1'b1;
      end else if (ctl.clear || (ctl.div_step && ctl.div_last)) begin
        dirty_r <= 1'b0;
      end else begin
        dirty_r <= dirty_r;
      end
      priority if (ctl.clear) begin
        mod_r <= '0;
      end else if (ctl.div_step) begin
        mod_r <= div_nxt;
      end else if (ctl.advance) begin
        mod_r <= adv_nxt;
      end else begin
        mod_r <= mod_r;
      end
      priority if (ctl.clear) begin
        work_r <= '0;
      end else if (ctl.job_start) begin
        work_r <= eff_wcet;
      end else if (ctl.dec && work_r != '0) begin
        work_r <= work_r - SLOT_W'(1);
      end else begin
        work_r <= work_r;
      end
    end
  end

  assign work      = work_r;
  assign sts.due   = (mod_r == '0);
  assign sts.busy  = (work_r != '0);
  assign sts.dirty = dirty_r;

endmodule

// ----- rtl/rmts_stack_cell.sv -----
// One level of the ready stack: loads a new job or trades entries with a neighbor.
module rmts_stack_cell import rmts_pkg::*; (
  input  logic              clk,
  input  stk_ctl_t          ctl,
  input  logic [TASK_W-1:0] up_entry,
  input  logic [TASK_W-1:0] dn_entry,
  output logic [TASK_W-1:0] entry
);

  logic [TASK_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      entry_r <= ctl.idx;
    end else if (ctl.take_dn) begin
      entry_r <= dn_entry;
    end else if (ctl.take_up) begin
      entry_r <= up_entry;
    end else begin
      entry_r <= entry_r;
    end
  end

  assign entry = entry_r;

endmodule

// ----- rtl/rate_monotonic_tick_scheduler.sv -----
// Top level of the rate monotonic tick scheduler: sequencer, task cells and ready stack.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | in_tdata[0] restart
//  out     | out | out_tvalid/tready  | out_tdata: slot, idle, run_task, work_left, overrun, depth
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata
//
// A tick runs the release pass over the tasks in use and then the RUN step; each released
// job is compare-swapped against every job already on the stack; after a period write the
// next tick without restart first runs the bit-serial slot remainder in the task cells.
// Synchronous reset; control state clears at once, no clearing pass.
// A result waits in the output register; a full register holds the sequencer in RUN.
module rate_monotonic_tick_scheduler import rmts_pkg::*; #(
  parameter int MAX_TASKS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // slot, idle, run_task, work_left, overrun_mask,
                                            // ready_depth
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  state_t state_r, state_nxt;

  logic [TASK_W-1:0]    task_count_r, used, tix_r;
  logic [SLOT_W-1:0]    hyper_r, slot_r, slot_nxt, hp_eff;
  logic [SLOT_W:0]      slot_inc;
  logic                 slot_wrap;
  logic [FILL_W-1:0]    fill_r;
  logic [SIDX_W-1:0]    k_r;
  logic [MASK_W-1:0]    mask_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic [39:0]          out_data_r;

  logic [SLOT_W-1:0] eff_per [MAX_TASKS];
  logic [SLOT_W-1:0] work    [MAX_TASKS];
  task_sts_t         sts     [MAX_TASKS];
  task_ctl_t         tctl    [MAX_TASKS];
  logic [TASK_W-1:0] entry   [MAX_TASKS];
  stk_ctl_t          sctl    [MAX_TASKS];

  logic              accept, restart, any_dirty, rel_active, rel_ok, full, run_fire;
  logic              cur_due, cur_busy, swap, is_idle, pop;
  logic [TASK_W-1:0] ent_k, ent_km1, top_ent;
  logic [SLOT_W-1:0] per_k, per_km1, top_work, top_left;
  logic [FILL_W-1:0] top_pos;

  assign accept  = in_tvalid && in_tready;
  assign restart = in_tdata[0];
  assign used    = (task_count_r > TASK_W'(MAX_TASKS)) ? TASK_W'(MAX_TASKS) : task_count_r;
  assign full    = (fill_r >= FILL_W'(MAX_TASKS));
  assign top_pos = fill_r - FILL_W'(1);

  always_comb begin
    any_dirty = 1'b0;
    cur_due   = 1'b0;
    cur_busy  = 1'b0;
    ent_k     = '0;
    ent_km1   = '0;
    top_ent   = '0;
    per_k     = '0;
    per_km1   = '0;
    top_work  = '0;
    for (int t = 0; t < MAX_TASKS; t++) begin
      any_dirty = any_dirty | sts[t].dirty;
      if (tix_r == TASK_W'(t)) begin
        cur_due  = sts[t].due;
        cur_busy = sts[t].busy;
      end
    end
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (k_r == SIDX_W'(j)) begin
        ent_k = entry[j];
      end
      if (k_r == SIDX_W'(j + 1)) begin
        ent_km1 = entry[j];
      end
      if (top_pos == FILL_W'(j)) begin
        top_ent = entry[j];
      end
    end
    for (int t = 0; t < MAX_TASKS; t++) begin
      if (ent_k == TASK_W'(t)) begin
        per_k = eff_per[t];
      end
      if (ent_km1 == TASK_W'(t)) begin
        per_km1 = eff_per[t];
      end
      if (top_ent == TASK_W'(t)) begin
        top_work = work[t];
      end
    end
  end

  assign rel_active = (state_r == ST_REL) && (tix_r < used);
  assign rel_ok     = rel_active && cur_due && !cur_busy && !full;
  assign swap       = (per_k > per_km1);
  assign run_fire   = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  assign is_idle    = (fill_r == '0);
  assign top_left   = (top_work != '0) ? top_work - SLOT_W'(1) : '0;
  assign pop        = !is_idle && (top_left == '0);

  assign hp_eff    = (hyper_r == '0) ? SLOT_W'(1) : hyper_r;
  assign slot_inc  = {1'b0, slot_r} + (SLOT_W+1)'(1);
  assign slot_wrap = (slot_inc >= {1'b0, hp_eff});
  assign slot_nxt  = slot_wrap ? '0 : slot_inc[SLOT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (any_dirty && !restart) ? ST_DIV : ST_REL;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(SLOT_W - 1)) begin
          state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        if (!rel_active) begin
          state_nxt = ST_RUN;
        end else if (rel_ok && fill_r != '0) begin
          state_nxt = ST_BUB;
        end
      end
      ST_BUB: begin
        if (k_r == SIDX_W'(1)) begin
          state_nxt = ST_REL;
        end
      end
      ST_RUN: begin
        if (run_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell controls
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    for (int t = 0; t < MAX_TASKS; t++) begin
      tctl[t].clear     = accept && restart;
      tctl[t].div_step  = (state_r == ST_DIV);
      tctl[t].div_first = (cnt_r == '0);
      tctl[t].div_last  = (cnt_r == DIV_CNT_W'(SLOT_W - 1));
      tctl[t].div_bit   = slot_r[DIV_CNT_W'(SLOT_W - 1) - cnt_r];
      tctl[t].job_start = rel_ok && (tix_r == TASK_W'(t));
      tctl[t].dec       = run_fire && !is_idle && (top_ent == TASK_W'(t));
      tctl[t].advance   = run_fire;
      tctl[t].wrap      = slot_wrap;
    end
    for (int j = 0; j < MAX_TASKS; j++) begin
      sctl[j].load    = rel_ok && (fill_r == FILL_W'(j));
      sctl[j].idx     = tix_r;
      sctl[j].take_dn = (state_r == ST_BUB) && swap && (k_r == SIDX_W'(j));
      sctl[j].take_up = (state_r == ST_BUB) && swap && (k_r == SIDX_W'(j + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
      hyper_r      <= SLOT_W'(1);
      slot_r       <= '0;
      fill_r       <= '0;
      tix_r        <= '0;
      k_r          <= '0;
      mask_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_TASK_COUNT) begin
        task_count_r <= cfg_wdata[TASK_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_HYPERPERIOD) begin
        hyper_r <= cfg_wdata;
      end
      if (accept) begin
        tix_r  <= '0;
        mask_r <= '0;
        cnt_r  <= '0;
        if (restart) begin
          slot_r <= '0;
          fill_r <= '0;
        end
      end
      if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      if (rel_active) begin
        tix_r <= tix_r + TASK_W'(1);
        if (rel_ok) begin
          fill_r <= fill_r + FILL_W'(1);
          k_r    <= SIDX_W'(fill_r);
        end else if (cur_due) begin
          mask_r[tix_r] <= 1'b1;
        end
      end
      if (state_r == ST_BUB) begin
        k_r <= k_r - SIDX_W'(1);
      end
      if (run_fire) begin
        slot_r <= slot_nxt;
        if (pop) begin
          fill_r <= fill_r - FILL_W'(1);
        end
      end
      if (run_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_fire) begin
      out_data_r <= {pop ? fill_r - FILL_W'(1) : fill_r,
                     mask_r,
                     is_idle ? SLOT_W'(0) : top_left,
                     is_idle ? TASK_W'(0) : top_ent,
                     is_idle,
                     slot_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  for (genvar t = 0; t < MAX_TASKS; t++) begin : g_task
    rmts_task_cell u_task (
      .clk        (clk),
      .rst_n      (rst_n),
      .period_we  (cfg_we && cfg_index == CFG_PERIOD_A + CFG_IDX_W'(t)),
      .wcet_we    (cfg_we && cfg_index == CFG_WCET_A + CFG_IDX_W'(t)),
      .wdata      (cfg_wdata),
      .ctl        (tctl[t]),
      .eff_period (eff_per[t]),
      .work       (work[t]),
      .sts        (sts[t])
    );
  end

  for (genvar j = 0; j < MAX_TASKS; j++) begin : g_stack
    logic [TASK_W-1:0] up_e, dn_e;
    if (j + 1 < MAX_TASKS) begin : g_up
      assign up_e = entry[j+1];
    end else begin : g_noup
      assign up_e = '0;
    end
    if (j > 0) begin : g_dn
      assign dn_e = entry[j-1];
    end else begin : g_nodn
      assign dn_e = '0;
    end
    rmts_stack_cell u_stk (
      .clk      (clk),
      .ctl      (sctl[j]),
      .up_entry (up_e),
      .dn_entry (dn_e),
      .entry    (entry[j])
    );
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_TASKS))
    else $error("ready stack fill beyond depth");

  a_bub_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BUB |-> (k_r != '0) && (FILL_W'(k_r) < fill_r))
    else $error("compare-swap position outside stack");

  a_top_work: assert property (@(posedge clk) disable iff (!rst_n)
    run_fire && !is_idle |-> top_work != '0)
    else $error("stacked job without pending work");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && cnt_r != DIV_CNT_W'(SLOT_W - 1) |=> state_r == ST_DIV)
    else $error("remainder pass cut short");
`endif

endmodule

// ----- tb/sv/tb_rate_monotonic_tick_scheduler.sv -----
// Testbench for the rate monotonic tick scheduler: directed and random ticks checked against a predictor.
module tb_rate_monotonic_tick_scheduler import rmts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  depth;
    logic [2:0]  overrun;
    logic [15:0] work_left;
    logic [1:0]  run_task;
    logic        idle;
    logic [15:0] slot;
  } tick_result_t;

  class rm_slot_predictor;
    bit [1:0]     task_count = 0;
    bit [15:0]    period[3] = '{1, 1, 1};
    bit [15:0]    wcet[3] = '{1, 1, 1};
    bit [15:0]    hyper = 1;
    bit [15:0]    slot_ctr = 0;
    bit [15:0]    work[3] = '{0, 0, 0};
    bit [1:0]     ready[3] = '{0, 0, 0};
    int unsigned  fill = 0;
    tick_result_t due_results[$];
    int unsigned  errors = 0;
    int unsigned  idle_slots = 0;
    int unsigned  skip_slots = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == CFG_TASK_COUNT) task_count = val[1:0];
      else if (idx == CFG_HYPERPERIOD) hyper = val;
      else if (idx >= CFG_WCET_A) wcet[idx - CFG_WCET_A] = val;
      else period[idx - CFG_PERIOD_A] = val;
    endfunction

    function bit [15:0] eff_period(bit [1:0] t);
      return period[t] == 0 ? 16'd1 : period[t];
    endfunction

    function void note_tick(bit restart);
      tick_result_t r;
      bit [1:0]     top, tmp;
      bit [15:0]    hp;
      int unsigned  nxt;
      r = '0;
      if (restart) begin
        slot_ctr = 0;
        fill = 0;
        foreach (work[i]) work[i] = 0;
      end
      r.slot = slot_ctr;
      for (int i = 0; i < task_count; i++) begin
        if (slot_ctr % eff_period(2'(i)) != 0) continue;
        if (work[i] != 0 || fill >= 3) begin
          r.overrun[i] = 1'b1;
          continue;
        end
        work[i] = wcet[i] == 0 ? 16'd1 : wcet[i];
        ready[fill] = 2'(i);
        // sink the new job below any job with a shorter period
        for (int k = fill; k > 0; k--) begin
          if (eff_period(ready[k]) > eff_period(ready[k-1])) begin
            tmp = ready[k];
            ready[k] = ready[k-1];
            ready[k-1] = tmp;
          end
        end
        fill++;
      end
      if (fill != 0) begin
        top = ready[fill-1];
        r.run_task = top;
        if (work[top] != 0) work[top]--;
        r.work_left = work[top];
        if (work[top] == 0) fill--;
      end else begin
        r.idle = 1'b1;
        idle_slots++;
      end
      if (r.overrun != 0) skip_slots++;
      r.depth = 2'(fill);
      hp = hyper == 0 ? 16'd1 : hyper;
      nxt = slot_ctr + 1;
      slot_ctr = nxt >= hp ? 16'd0 : nxt[15:0];
      due_results.push_back(r);
    endfunction

    function void report(string name, logic [15:0] exp_v, logic [15:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
    endfunction

    function void check_result(logic [39:0] data);
      tick_result_t act, exp_r;
      act = data;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, data);
        return;
      end
      exp_r = due_results.pop_front();
      if (exp_r.slot !== act.slot) report("slot", exp_r.slot, act.slot);
      if (exp_r.idle !== act.idle) report("idle", exp_r.idle, act.idle);
      if (exp_r.run_task !== act.run_task) report("run_task", exp_r.run_task, act.run_task);
      if (exp_r.work_left !== act.work_left) report("work_left", exp_r.work_left, act.work_left);
      if (exp_r.overrun !== act.overrun) report("overrun_mask", exp_r.overrun, act.overrun);
      if (exp_r.depth !== act.depth) report("ready_depth", exp_r.depth, act.depth);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rm_slot_predictor sb = new();
  bit               calm = 1'b0;
  int unsigned      n_ticks = 0;
  int unsigned      n_restarts = 0;
  int unsigned      n_phases = 0;

  rate_monotonic_tick_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // write one register; caller lowers cfg_we after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_all(input logic [1:0] tc, input logic [15:0] p0, p1, p2,
                             input logic [15:0] w0, w1, w2, hp);
    write_reg(CFG_TASK_COUNT, {14'd0, tc});
    write_reg(CFG_PERIOD_A, p0);
    write_reg(CFG_IDX_W'(CFG_PERIOD_A + 1), p1);
    write_reg(CFG_IDX_W'(CFG_PERIOD_A + 2), p2);
    write_reg(CFG_WCET_A, w0);
    write_reg(CFG_IDX_W'(CFG_WCET_A + 1), w1);
    write_reg(CFG_IDX_W'(CFG_WCET_A + 2), w2);
    write_reg(CFG_HYPERPERIOD, hp);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  task automatic send_tick(input bit restart);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(restart);
    n_ticks++;
    if (restart) n_restarts++;
    @(negedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // all results in, then room for the slowest tick
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 10));
    if (r < 80) return 16'd0;
    if (r < 90) return 16'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] pick_wcet();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(1, 4));
    if (r < 83) return 16'd0;
    if (r < 92) return 16'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] pick_hyper();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 60));
    if (r < 70) return 16'd0;
    if (r < 85) return 16'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  // result sink with random back-pressure
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      @(negedge clk);
      if (stall != 0 && !calm) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = calm ? 0 : pick_gap();
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for results");
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: no tasks in use
    send_tick(1'b0);
    send_tick(1'b0);
    wait_drained();

    // zero period, zero WCET and zero hyperperiod
    program_all(2'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (3) send_tick(1'b0);
    wait_drained();

    // widest values, but for a period of 1 on task 1
    program_all(2'd3, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_drained();

    // counter left above a lowered hyperperiod, task 1 dropped after its last job has finished
    program_all(2'd2, 16'd2, 16'd3, 16'd5, 16'd1, 16'd4, 16'd1, 16'd20);
    send_tick(1'b1);
    repeat (8) send_tick(1'b0);
    wait_drained();
    write_reg(CFG_TASK_COUNT, 16'd1);
    write_reg(CFG_HYPERPERIOD, 16'd4);
    cfg_we <= 1'b0;
    repeat (3) send_tick(1'b0);
    wait_drained();

    while (n_ticks < 830) begin
      calm = $urandom_range(0, 3) == 0;
      if ($urandom_range(0, 3) == 0) write_reg(CFG_TASK_COUNT, 16'($urandom_range(0, 2)));
      else write_reg(CFG_TASK_COUNT, 16'd3);
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 9) < 7) write_reg(CFG_IDX_W'(CFG_PERIOD_A + i), pick_period());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_IDX_W'(CFG_WCET_A + i), pick_wcet());
      end
      if ($urandom_range(0, 9) < 7) write_reg(CFG_HYPERPERIOD, pick_hyper());
      cfg_we <= 1'b0;
      n_phases++;
      @(negedge clk);
      len = $urandom_range(20, 60);
      send_tick($urandom_range(0, 9) < 7);
      repeat (len - 1) send_tick($urandom_range(0, 24) == 0);
      wait_drained();
    end
    calm = 1'b0;

    $display("Covered %0d ticks in %0d settings with %0d restarts", n_ticks, n_phases,
             n_restarts);
    $display("Idle slots: %0d, slots with skipped releases: %0d", sb.idle_slots,
             sb.skip_slots);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rmts_pkg.sv
rtl/rmts_task_cell.sv
rtl/rmts_stack_cell.sv
rtl/rate_monotonic_tick_scheduler.sv
tb/sv/tb_rate_monotonic_tick_scheduler.sv
